@@ hw/rtl/pva_pkg.sv @@
`default_nettype none

package pva_pkg;

	// Pool size and age stamp width
	localparam int NUM_VOICES = 8;
	localparam int AGE_BITS   = 32;
	localparam int VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	// Result masks cover voices 0..7 only
	localparam int OUT_MASK_W = 8;
	localparam int MASK_N     = (NUM_VOICES < OUT_MASK_W) ? NUM_VOICES : OUT_MASK_W;

	// Operation codes
	localparam logic [1:0] OP_NOTE_ON  = 2'd0;
	localparam logic [1:0] OP_NOTE_OFF = 2'd1;
	localparam logic [1:0] OP_FINISH   = 2'd2;

	// Search wave that walks the voice chain, one cell per cycle
	typedef struct packed {
		logic                valid;
		logic                same_hit;
		logic [VOICE_W-1:0]  same_idx;
		logic                free_hit;
		logic [VOICE_W-1:0]  free_idx;
		logic                min_hit;
		logic [AGE_BITS-1:0] min_age;
		logic [VOICE_W-1:0]  min_idx;
	} pva_sweep_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_ASSIGN,
		CMD_RELEASE,
		CMD_FINISH
	} pva_cmd_kind_t;

	// Update broadcast to every cell
	typedef struct packed {
		pva_cmd_kind_t       kind;
		logic [6:0]          note;
		logic [AGE_BITS-1:0] age;
		logic [VOICE_W-1:0]  idx;
	} pva_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/poly_voice_allocator_top.sv @@
`default_nettype none

// Polyphonic voice allocator. Each beat on the input carries one event (note on, note off or
// envelope finished) and produces exactly one result beat. A note on with nonzero velocity
// sends a search record down a chain of NUM_VOICES voice cells, one cell per cycle, to find
// the voice (same active note, else lowest free voice, else smallest age stamp) before the
// update is applied; every other event goes straight to the apply step. One event is in
// flight at a time; a finished result waits in an output register, so the next event may be
// taken before the previous result is collected.
module poly_voice_allocator_top
	import pva_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            operation,
	input  wire logic [6:0]            note_number,
	input  wire logic [6:0]            note_velocity,
	input  wire logic [2:0]            finished_voice,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [2:0]                 chosen_voice,
	output logic                       voice_assigned,
	output logic                       was_stolen,
	output logic                       same_note_retrigger,
	output logic [OUT_MASK_W-1:0]      released_mask,
	output logic [OUT_MASK_W-1:0]      active_mask,
	output logic [OUT_MASK_W-1:0]      gate_mask
);

	pva_sweep_t            chain [NUM_VOICES+1];
	pva_cmd_t              cmd;
	logic [NUM_VOICES-1:0] active_vec;
	logic [NUM_VOICES-1:0] gate_vec;
	logic [NUM_VOICES-1:0] release_vec;

	pva_ctrl u_ctrl (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.operation           (operation),
		.note_number         (note_number),
		.note_velocity       (note_velocity),
		.finished_voice      (finished_voice),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.chosen_voice        (chosen_voice),
		.voice_assigned      (voice_assigned),
		.was_stolen          (was_stolen),
		.same_note_retrigger (same_note_retrigger),
		.released_mask       (released_mask),
		.active_mask         (active_mask),
		.gate_mask           (gate_mask),
		.sweep_launch        (chain[0]),
		.sweep_tail          (chain[NUM_VOICES]),
		.cmd                 (cmd),
		.active_vec          (active_vec),
		.gate_vec            (gate_vec),
		.release_vec         (release_vec)
	);

	// Row of voice cells, each passing the search record to its neighbour
	for (genvar i = 0; i < NUM_VOICES; i++) begin : g_voice
		pva_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cell_idx    (VOICE_W'(i)),
			.sweep_in    (chain[i]),
			.sweep_out   (chain[i+1]),
			.cmd         (cmd),
			.active      (active_vec[i]),
			.gate        (gate_vec[i]),
			.release_hit (release_vec[i])
		);
	end

endmodule

`default_nettype wire

@@ hw/rtl/pva_cell.sv @@
`default_nettype none

module pva_cell
	import pva_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [VOICE_W-1:0]  cell_idx,
	input  wire pva_sweep_t          sweep_in,
	output pva_sweep_t               sweep_out,
	input  wire pva_cmd_t            cmd,
	output logic                     active,
	output logic                     gate,
	output logic                     release_hit
);

	logic                active_q;
	logic                gate_q;
	logic [6:0]          note_q;
	logic [AGE_BITS-1:0] age_q;
	pva_sweep_t          sweep_q;
	pva_sweep_t          sweep_d;
	logic                note_match;
	logic                idx_match;

	assign note_match = (note_q == cmd.note);
	assign idx_match  = (cmd.idx == cell_idx);

	// Fold this voice into the passing search record
	always_comb begin
		sweep_d = sweep_in;
		if (!sweep_in.same_hit && active_q && note_match) begin
			sweep_d.same_hit = 1'b1;
			sweep_d.same_idx = cell_idx;
		end
		if (!sweep_in.free_hit && !active_q) begin
			sweep_d.free_hit = 1'b1;
			sweep_d.free_idx = cell_idx;
		end
		if (!sweep_in.min_hit || (age_q < sweep_in.min_age)) begin
			sweep_d.min_hit = 1'b1;
			sweep_d.min_age = age_q;
			sweep_d.min_idx = cell_idx;
		end
	end

	// Hand the record to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else begin
			sweep_q <= sweep_d;
		end
	end

	// Flags of this voice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			gate_q   <= 1'b0;
		end else begin
			case (cmd.kind)
				CMD_ASSIGN: begin
					if (idx_match) begin
						active_q <= 1'b1;
						gate_q   <= 1'b1;
					end
				end
				CMD_RELEASE: begin
					if (active_q && note_match) begin
						gate_q <= 1'b0;
					end
				end
				CMD_FINISH: begin
					if (idx_match) begin
						active_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Note and age stamp of this voice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q <= '0;
			age_q  <= '0;
		end else if (cmd.kind == CMD_ASSIGN && idx_match) begin
			note_q <= cmd.note;
			age_q  <= cmd.age;
		end
	end

	assign release_hit = (cmd.kind == CMD_RELEASE) && active_q && gate_q && note_match;
	assign sweep_out   = sweep_q;
	assign active      = active_q;
	assign gate        = gate_q;

endmodule

`default_nettype wire

@@ hw/rtl/pva_ctrl.sv @@
`default_nettype none

module pva_ctrl
	import pva_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            operation,
	input  wire logic [6:0]            note_number,
	input  wire logic [6:0]            note_velocity,
	input  wire logic [2:0]            finished_voice,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [2:0]                 chosen_voice,
	output logic                       voice_assigned,
	output logic                       was_stolen,
	output logic                       same_note_retrigger,
	output logic [OUT_MASK_W-1:0]      released_mask,
	output logic [OUT_MASK_W-1:0]      active_mask,
	output logic [OUT_MASK_W-1:0]      gate_mask,
	output pva_sweep_t                 sweep_launch,
	input  wire pva_sweep_t            sweep_tail,
	output pva_cmd_t                   cmd,
	input  wire logic [NUM_VOICES-1:0] active_vec,
	input  wire logic [NUM_VOICES-1:0] gate_vec,
	input  wire logic [NUM_VOICES-1:0] release_vec
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_APPLY,
		ST_REPORT
	} state_t;

	state_t                  state_q;
	logic                    launch_q;
	logic [1:0]              op_q;
	logic [6:0]              note_q;
	logic                    vel_nz_q;
	logic [2:0]              fin_q;
	logic [VOICE_W-1:0]      pick_q;
	logic                    assign_q;
	logic                    stolen_q;
	logic                    retrig_q;
	logic [NUM_VOICES-1:0]   released_q;
	logic [AGE_BITS-1:0]     age_count_q;
	logic                    out_valid_q;
	logic [2:0]              chosen_q;
	logic                    assigned_q;
	logic                    was_stolen_q;
	logic                    retrigger_q;
	logic [OUT_MASK_W-1:0]   released_mask_q;
	logic [OUT_MASK_W-1:0]   active_mask_q;
	logic [OUT_MASK_W-1:0]   gate_mask_q;
	logic                    accept;
	logic                    is_assign_in;
	logic                    fin_in_range;

	function automatic logic [OUT_MASK_W-1:0] to_mask(input logic [NUM_VOICES-1:0] v);
		logic [OUT_MASK_W-1:0] r;
		r = '0;
		r[MASK_N-1:0] = v[MASK_N-1:0];
		return r;
	endfunction

	assign in_ready     = (state_q == ST_IDLE);
	assign accept       = in_valid && in_ready;
	assign is_assign_in = (operation == OP_NOTE_ON) && (note_velocity != 7'd0);
	assign fin_in_range = (32'(fin_q) < NUM_VOICES);

	// Start the search wave at the head of the chain
	always_comb begin
		sweep_launch       = '0;
		sweep_launch.valid = launch_q;
	end

	// Broadcast update during the apply cycle
	always_comb begin
		cmd      = '0;
		cmd.note = note_q;
		cmd.age  = age_count_q;
		cmd.idx  = pick_q;
		if (state_q == ST_APPLY) begin
			case (op_q)
				OP_NOTE_ON: begin
					cmd.kind = vel_nz_q ? CMD_ASSIGN : CMD_RELEASE;
				end
				OP_NOTE_OFF: begin
					cmd.kind = CMD_RELEASE;
				end
				OP_FINISH: begin
					cmd.kind = fin_in_range ? CMD_FINISH : CMD_NONE;
					cmd.idx  = VOICE_W'(fin_q);
				end
				default: begin
					cmd.kind = CMD_NONE;
				end
			endcase
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			launch_q        <= 1'b0;
			op_q            <= OP_NOTE_ON;
			note_q          <= '0;
			vel_nz_q        <= 1'b0;
			fin_q           <= '0;
			pick_q          <= '0;
			assign_q        <= 1'b0;
			stolen_q        <= 1'b0;
			retrig_q        <= 1'b0;
			released_q      <= '0;
			age_count_q     <= '0;
			out_valid_q     <= 1'b0;
			chosen_q        <= '0;
			assigned_q      <= 1'b0;
			was_stolen_q    <= 1'b0;
			retrigger_q     <= 1'b0;
			released_mask_q <= '0;
			active_mask_q   <= '0;
			gate_mask_q     <= '0;
		end else begin
			launch_q <= accept && is_assign_in;
			// Raise the result beat when loaded, drop it once taken
			if (state_q == ST_REPORT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q       <= operation;
						note_q     <= note_number;
						vel_nz_q   <= (note_velocity != 7'd0);
						fin_q      <= finished_voice;
						pick_q     <= '0;
						assign_q   <= is_assign_in;
						stolen_q   <= 1'b0;
						retrig_q   <= 1'b0;
						released_q <= '0;
						if (is_assign_in) begin
							state_q  <= ST_SWEEP;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_SWEEP: begin
					// Pick: same note, then free voice, then oldest
					if (sweep_tail.valid) begin
						if (sweep_tail.same_hit) begin
							pick_q <= sweep_tail.same_idx;
						end else if (sweep_tail.free_hit) begin
							pick_q <= sweep_tail.free_idx;
						end else begin
							pick_q <= sweep_tail.min_idx;
						end
						retrig_q <= sweep_tail.same_hit;
						stolen_q <= !sweep_tail.same_hit && !sweep_tail.free_hit;
						state_q  <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					released_q <= release_vec;
					if (cmd.kind == CMD_ASSIGN) begin
						age_count_q <= age_count_q + 1'b1;
					end
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					// Hold until the result register is free
					if (!out_valid_q || out_ready) begin
						chosen_q        <= 3'(pick_q);
						assigned_q      <= assign_q;
						was_stolen_q    <= stolen_q;
						retrigger_q     <= retrig_q;
						released_mask_q <= to_mask(released_q);
						active_mask_q   <= to_mask(active_vec);
						gate_mask_q     <= to_mask(gate_vec);
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid           = out_valid_q;
	assign chosen_voice        = chosen_q;
	assign voice_assigned      = assigned_q;
	assign was_stolen          = was_stolen_q;
	assign same_note_retrigger = retrigger_q;
	assign released_mask       = released_mask_q;
	assign active_mask         = active_mask_q;
	assign gate_mask           = gate_mask_q;

`ifndef ASSERT_OFF
	a_tail_only_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_tail.valid |-> (state_q == ST_SWEEP))
		else $error("search wave left the chain outside a sweep");

	a_steal_xor_retrig: assert property (@(posedge clk) disable iff (!arst_n)
		!(stolen_q && retrig_q))
		else $error("voice both stolen and retriggered");

	a_age_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY && cmd.kind == CMD_ASSIGN) |=>
		(age_count_q == AGE_BITS'($past(age_count_q) + 1'b1)))
		else $error("age count did not advance after an assignment");

	a_assign_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && assigned_q) |-> (released_mask_q == '0))
		else $error("assignment reported a released voice");
`endif

endmodule

`default_nettype wire
